### design/pqle_pkg.sv
`default_nettype none

package pqle_pkg;

  // Width of the cell index carried on the command bus (covers 256 slots)
  localparam int IDX_W = 8;

  typedef enum logic [2:0] {
    K_ENQUEUE = 3'd0,
    K_DEQUEUE = 3'd1,
    K_SEARCH  = 3'd2,
    K_INSERT  = 3'd3,
    K_MODIFY  = 3'd4,
    K_DELETE  = 3'd5,
    K_CLEAR   = 3'd6,
    K_NOP     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   idx;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         found_position;
    logic [4:0]         occupancy;
  } out_item_t;

endpackage

`default_nettype wire

### design/pqle_chan_if.sv
`default_nettype none

interface pqle_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/pqle_cell.sv
`default_nettype none

module pqle_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire pqle_pkg::cell_cmd_t   cmd,
  input  wire logic [DATA_WIDTH-1:0] word,
  input  wire logic [DATA_WIDTH-1:0] left_entry,
  input  wire logic [DATA_WIDTH-1:0] right_entry,
  output logic      [DATA_WIDTH-1:0] entry,
  output logic                       match
);
  import pqle_pkg::*;

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  at_idx;
  logic                  past_idx;

  assign at_idx   = (cmd.idx == IDX_W'(INDEX));
  assign past_idx = (IDX_W'(INDEX) > cmd.idx);

  // Pick the new entry: own word, left neighbor on insert, right neighbor on removal
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_LOAD: begin
        if (at_idx) entry_nxt = word;
      end
      CELL_INSERT: begin
        if (at_idx) entry_nxt = word;
        else if (past_idx) entry_nxt = left_entry;
      end
      CELL_REMOVE: begin
        if (at_idx || past_idx) entry_nxt = right_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == word);

endmodule

`default_nettype wire

### design/positional_queue_list_engine.sv
// Channel | Dir | Interface port | Payload
// --------+-----+----------------+-------------------------------------------
// in      | in  | in_ch (sink)   | kind, position, value
// out     | out | out_ch (source)| status, read_value, found_position, occupancy
//
// One item per cycle while out_ch keeps taking results: each operation finishes
// in the cycle it is accepted; the list is a row of cells that shift, load and
// compare in parallel, and the result is registered in the output register.
// Reset (rst_n low, synchronous) empties the list; entries are not cleared.
// A stalled result holds the output register; in_ch.ready drops only while
// that register is full and out_ch.ready is low.
`default_nettype none

module positional_queue_list_engine #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pqle_chan_if.sink   in_ch,
  pqle_chan_if.source out_ch
);
  import pqle_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;

  logic                  accept;
  kind_t                 kind;
  logic [4:0]            pos;
  logic [DATA_WIDTH-1:0] word;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic                  full;
  logic                  empty;

  cell_cmd_t             cmd;
  cell_cmd_t             cell_cmd;
  status_t               status_c;
  logic [31:0]           rd_c;
  logic [4:0]            found_c;

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [DEPTH-1:0]      match_bits;
  logic                  hit;
  logic [IW-1:0]         hit_idx;

  assign accept = in_ch.valid && in_ch.ready;
  assign kind   = kind_t'(in_ch.data.kind);
  assign pos    = in_ch.data.position;
  assign word   = DATA_WIDTH'($unsigned(in_ch.data.value));
  assign pos_ext = CMPW'(pos);
  assign cnt_ext = CMPW'(count_r);
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  // Row of cells, each passing its entry to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = word;
    end else begin : g_inner_l
      assign left_w = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = entries[i];
    end else begin : g_inner_r
      assign right_w = entries[i+1];
    end

    pqle_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .word        (word),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (entries[i]),
      .match       (match_bits[i])
    );
  end

  // Find the first live cell that matches the target
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_bits[i] && (CW'(i) < count_r)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // Decode the operation: status, result fields, cell command, new count
  always_comb begin
    status_c  = ST_OK;
    rd_c      = '0;
    found_c   = '0;
    count_nxt = count_r;
    cmd.op    = CELL_HOLD;
    cmd.idx   = '0;
    case (kind)
      K_ENQUEUE: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          cmd.op    = CELL_LOAD;
          cmd.idx   = IDX_W'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      K_DEQUEUE: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          rd_c      = 32'(entries[0]);
          cmd.op    = CELL_REMOVE;
          cmd.idx   = '0;
          count_nxt = count_r - 1'b1;
        end
      end
      K_SEARCH: begin
        if (hit) begin
          found_c = 5'(hit_idx) + 5'd1;
        end else begin
          status_c = ST_NOTFOUND;
        end
      end
      K_INSERT: begin
        if (full) begin
          status_c = ST_FULL;
        end else if (pos == 5'd0 || pos_ext > cnt_ext + 1'b1) begin
          status_c = ST_BADPOS;
        end else begin
          cmd.op    = CELL_INSERT;
          cmd.idx   = IDX_W'(pos) - 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      K_MODIFY: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (pos == 5'd0 || pos_ext > cnt_ext) begin
          status_c = ST_BADPOS;
        end else begin
          cmd.op  = CELL_LOAD;
          cmd.idx = IDX_W'(pos) - 1'b1;
        end
      end
      K_DELETE: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (pos == 5'd0 || pos_ext > cnt_ext) begin
          status_c = ST_BADPOS;
        end else begin
          cmd.op    = CELL_REMOVE;
          cmd.idx   = IDX_W'(pos) - 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      K_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  // Drive the cells only for an accepted item
  always_comb begin
    cell_cmd = cmd;
    if (!accept) cell_cmd.op = CELL_HOLD;
  end

  // Build the result item
  always_comb begin
    out_data_nxt.status         = status_c;
    out_data_nxt.read_value     = $signed(rd_c);
    out_data_nxt.found_position = found_c;
    out_data_nxt.occupancy      = 5'(count_nxt);
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  // Advance count and the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) count_r <= count_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A refused operation leaves the list length alone
  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_c == ST_FULL || status_c == ST_EMPTY || status_c == ST_BADPOS)
    |=> $stable(count_r))
    else $error("refused operation changed the count");

  // Clear empties the list
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == K_CLEAR |=> count_r == '0)
    else $error("clear left entries in the list");

  // A successful enqueue grows the list by one
  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == K_ENQUEUE && status_c == ST_OK
    |=> count_r == $past(count_r) + 1'b1)
    else $error("enqueue did not grow the list");

  // Every accepted item shows up in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_data_r.occupancy == 5'(count_r))
    else $error("result missing or occupancy out of step");

  // The list never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count beyond depth");

endmodule

`default_nettype wire

### tb/pqle_checker.sv
module pqle_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pqle_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pqle_pkg::out_item_t out_data,
  output int                  failures,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pqle_pkg::*;

  localparam int LIST_DEPTH = 16;

  // Shadow copy of the list and its fill level
  logic [31:0] slots [LIST_DEPTH];
  int          fill;
  out_item_t   expected_results [$];
  int          mismatches = 0;
  int          waiting = 0;

  assign failures    = mismatches;
  assign outstanding = waiting;

  // Apply one list operation to the shadow list and return the result item
  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t res;
    int        slot;
    res        = '0;
    res.status = ST_OK;
    slot       = op.position;
    case (kind_t'(op.kind))
      K_ENQUEUE: begin
        if (fill >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slots[fill] = op.value;
          fill++;
        end
      end
      K_DEQUEUE: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = slots[0];
          for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
          fill--;
        end
      end
      K_SEARCH: begin
        // First match wins; stale slots past the fill level never match
        res.status = ST_NOTFOUND;
        for (int i = 0; i < fill && res.status != ST_OK; i++) begin
          if (slots[i] == op.value) begin
            res.found_position = 5'(i + 1);
            res.status         = ST_OK;
          end
        end
      end
      K_INSERT: begin
        // Full is checked ahead of the position
        if (fill >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (slot < 1 || slot > fill + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = fill; i >= slot; i--) slots[i] = slots[i-1];
          slots[slot-1] = op.value;
          fill++;
        end
      end
      K_MODIFY: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else if (slot < 1 || slot > fill) begin
          res.status = ST_BADPOS;
        end else begin
          slots[slot-1] = op.value;
        end
      end
      K_DELETE: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else if (slot < 1 || slot > fill) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = slot; i < fill; i++) slots[i-1] = slots[i];
          fill--;
        end
      end
      K_CLEAR: begin
        fill = 0;
      end
      default: begin
      end
    endcase
    res.occupancy = 5'(fill);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Retire results first, then record the new item's expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with nothing outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("found_position", 32'(want.found_position),
                      32'(out_data.found_position));
          check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_list_op(in_data));
      end
    end
    waiting = expected_results.size();
  end

endmodule

### tb/positional_queue_list_engine_test.sv
module positional_queue_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pqle_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIX} mood_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          calm = 1'b0;
  int          fail_count;
  int          outstanding;
  int          cycles = 0;
  logic [31:0] value_pool [8];

  pqle_chan_if #(.item_t(in_item_t))  in_ch ();
  pqle_chan_if #(.item_t(out_item_t)) out_ch ();

  positional_queue_list_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pqle_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .failures    (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("positional_queue_list_engine test failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Bias the operation mix so the list swings between empty and full
  function automatic kind_t pick_kind(mood_t mood);
    int r;
    r = $urandom_range(0, 99);
    case (mood)
      MOOD_FILL: begin
        if (r < 45) return K_ENQUEUE;
        if (r < 75) return K_INSERT;
        if (r < 84) return K_SEARCH;
        if (r < 91) return K_MODIFY;
        if (r < 96) return K_DEQUEUE;
        return K_DELETE;
      end
      MOOD_DRAIN: begin
        if (r < 35) return K_DEQUEUE;
        if (r < 65) return K_DELETE;
        if (r < 75) return K_SEARCH;
        if (r < 83) return K_MODIFY;
        if (r < 90) return K_ENQUEUE;
        if (r < 97) return K_INSERT;
        if (r < 99) return K_CLEAR;
        return K_NOP;
      end
      default: begin
        if (r < 18) return K_ENQUEUE;
        if (r < 33) return K_DEQUEUE;
        if (r < 53) return K_SEARCH;
        if (r < 68) return K_INSERT;
        if (r < 81) return K_MODIFY;
        if (r < 95) return K_DELETE;
        if (r < 98) return K_CLEAR;
        return K_NOP;
      end
    endcase
  endfunction

  // Mostly legal slots, some anywhere in the field
  function automatic logic [4:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 5'($urandom_range(1, 17));
    if (r < 95) return 5'($urandom_range(0, 31));
    return 5'd0;
  endfunction

  // Draw from a small pool so searches find matches
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(kind_t kind, logic [4:0] position, logic [31:0] value);
    in_item_t item;
    int       gap;
    item.kind     = kind;
    item.position = position;
    item.value    = value;
    gap           = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Result side: random stalls between stretches of ready
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    mood_t mood;
    int    block_len;
    int    sent;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 8; i++) value_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-list cases
    send_item(K_DEQUEUE, 5'd0, 32'h0);
    send_item(K_SEARCH, 5'd0, 32'h0);
    send_item(K_MODIFY, 5'd1, 32'h1);
    send_item(K_DELETE, 5'd1, 32'h0);
    send_item(K_INSERT, 5'd0, 32'h1);
    send_item(K_INSERT, 5'd2, 32'h1);
    // Build a short list with extreme words, insert at head and tail
    send_item(K_INSERT, 5'd1, 32'h8000_0000);
    send_item(K_ENQUEUE, 5'd31, 32'h7FFF_FFFF);
    send_item(K_ENQUEUE, 5'd0, 32'hFFFF_FFFF);
    send_item(K_INSERT, 5'd4, 32'h0000_0000);
    send_item(K_INSERT, 5'd2, 32'h5555_AAAA);
    // Search hit and miss
    send_item(K_SEARCH, 5'd0, 32'hFFFF_FFFF);
    send_item(K_SEARCH, 5'd31, 32'h1234_5678);
    // Bad and good slots for modify and delete
    send_item(K_MODIFY, 5'd0, 32'h1);
    send_item(K_MODIFY, 5'd31, 32'h1);
    send_item(K_MODIFY, 5'd5, 32'hAAAA_5555);
    send_item(K_DELETE, 5'd6, 32'h0);
    send_item(K_DELETE, 5'd3, 32'h0);
    send_item(K_DEQUEUE, 5'd0, 32'h0);
    // Unused kind, then clear and confirm stale words are gone
    send_item(K_NOP, 5'd31, 32'hFFFF_FFFF);
    send_item(K_CLEAR, 5'd0, 32'h0);
    send_item(K_SEARCH, 5'd0, 32'h7FFF_FFFF);
    send_item(K_DEQUEUE, 5'd0, 32'h0);

    // Random blocks, each with its own operation mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mood      = mood_t'($urandom_range(0, 2));
      calm      = ($urandom_range(0, 3) == 0);
      block_len = $urandom_range(20, 60);
      for (int i = 5; i < 8; i++) value_pool[i] = $urandom;
      repeat (block_len) send_item(pick_kind(mood), pick_position(), pick_value());
      sent += block_len;
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the output register settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_queue_list_engine test passed");
    end else begin
      $display("positional_queue_list_engine test failed");
    end
    $finish;
  end

endmodule

### positional_queue_list_engine.f
design/pqle_pkg.sv
design/pqle_chan_if.sv
design/pqle_cell.sv
design/positional_queue_list_engine.sv
tb/pqle_checker.sv
tb/positional_queue_list_engine_test.sv
